// ===== design/jts_pkg.sv =====
package jts_pkg;

  typedef enum logic [4:0] {
    TK_END       = 5'd0,
    TK_OBJ_START = 5'd1,
    TK_OBJ_END   = 5'd2,
    TK_ARR_START = 5'd3,
    TK_ARR_END   = 5'd4,
    TK_TRUE      = 5'd5,
    TK_FALSE     = 5'd6,
    TK_NULL      = 5'd7,
    TK_INT       = 5'd8,
    TK_FLOAT     = 5'd9,
    TK_STR       = 5'd10,
    TK_FIELD     = 5'd11,
    TK_ERROR     = 5'd12,
    TK_NAN       = 5'd13,
    TK_INF       = 5'd14,
    TK_NEGINF    = 5'd15,
    TK_COMMA     = 5'd16
  } tok_t;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_LIT   = 3'd1,
    M_STR   = 3'd2,
    M_SDONE = 3'd3,
    M_NUM   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ER_NONE      = 3'd0,
    ER_COMMA     = 3'd1,
    ER_TRAILING  = 3'd2,
    ER_INVALID   = 3'd3,
    ER_PREMATURE = 3'd4,
    ER_BAD_NUM   = 3'd5,
    ER_UNTERM    = 3'd6,
    ER_SYNTAX    = 3'd7
  } err_t;

  localparam logic [2:0] LIT_LAST = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       row_end;
  } item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] val_offset;
    logic [16:0] value_length;
    logic [2:0]  error_kind;
    logic        has_escape;
    logic        run_last;
  } tok_beat_t;

  // row state other than the byte offsets
  typedef struct packed {
    mode_t      mode;
    tok_t       prev;
    logic [2:0] lsel;
    logic [3:0] lprog;
    logic       lmis;
    logic       esc;
    logic       skip;
    logic       flt;
    logic       err;
    logic       sign_only;
    logic       neg_lead;
  } scan_st_t;

  localparam scan_st_t SCAN_RESET = '{mode: M_IDLE, prev: TK_END, default: '0};

  function automatic logic [7:0] lit_char(input logic [2:0] sel, input logic [2:0] p);
    logic [63:0] s;
    begin
      unique case (sel)
        3'd0:    s = {"ull", 40'd0};
        3'd1:    s = {"rue", 40'd0};
        3'd2:    s = {"alse", 32'd0};
        3'd3:    s = "ndefined";
        3'd4:    s = {"aN", 48'd0};
        3'd5:    s = {"nfinity", 8'd0};
        default: s = "Infinity";
      endcase
      lit_char = s[63 - 8 * p -: 8];
    end
  endfunction

  function automatic logic [3:0] lit_len(input logic [2:0] sel);
    unique case (sel)
      3'd0, 3'd1: lit_len = 4'd3;
      3'd2:       lit_len = 4'd4;
      3'd3:       lit_len = 4'd8;
      3'd4:       lit_len = 4'd2;
      3'd5:       lit_len = 4'd7;
      default:    lit_len = 4'd8;
    endcase
  endfunction

  function automatic tok_t lit_kind(input logic [2:0] sel);
    unique case (sel)
      3'd0, 3'd3: lit_kind = TK_NULL;
      3'd1:       lit_kind = TK_TRUE;
      3'd2:       lit_kind = TK_FALSE;
      3'd4:       lit_kind = TK_NAN;
      3'd5:       lit_kind = TK_INF;
      default:    lit_kind = TK_NEGINF;
    endcase
  endfunction

  function automatic tok_beat_t mk_tok(input tok_t kind, input logic [15:0] start,
                                       input logic [16:0] len, input err_t ek,
                                       input logic esc);
    tok_beat_t t;
    begin
      t.token_kind   = kind[3:0];
      t.val_offset   = start;
      t.value_length = len;
      t.error_kind   = ek;
      t.has_escape   = esc;
      t.run_last     = 1'b0;
      mk_tok = t;
    end
  endfunction

endpackage

// ===== design/jts_step.sv =====
module jts_step #(
  parameter int MAX_ROW_BYTES = 65536,
  parameter int PW = $clog2(MAX_ROW_BYTES + 1)
) (
  input  jts_pkg::scan_st_t  st,
  input  logic [PW-1:0]      pos,
  input  logic [PW-1:0]      tstart,
  input  logic [PW-1:0]      held,
  input  jts_pkg::item_t     item,
  output jts_pkg::scan_st_t  st_next,
  output logic [PW-1:0]      pos_next,
  output logic [PW-1:0]      tstart_next,
  output logic [PW-1:0]      held_next,
  output jts_pkg::tok_beat_t res [3],
  output logic [1:0]         res_cnt
);

  localparam logic [PW-1:0] MAX_POS = PW'(MAX_ROW_BYTES);

  jts_pkg::scan_st_t  s;
  jts_pkg::tok_beat_t r [4];
  logic [1:0]         n;
  logic [PW-1:0]      ps, ts, hl;
  logic [7:0]         b;
  logic               do_idle, space, digit, taken;
  logic [2:0]         sel, p;

  always_comb begin
    s       = st;
    ps      = pos;
    ts      = tstart;
    hl      = held;
    b       = item.data_byte;
    n       = 2'd0;
    do_idle = 1'b0;
    taken   = 1'b0;
    sel     = (st.lsel > jts_pkg::LIT_LAST) ? jts_pkg::LIT_LAST : st.lsel;
    p       = st.lprog[2:0];
    space   = (b == " ") || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
    digit   = (b >= "0") && (b <= "9");
    for (int i = 0; i < 4; i++) begin
      r[i] = '0;
    end

    if (item.byte_present && !st.err) begin
      if (ps >= MAX_POS) begin
        r[n] = jts_pkg::mk_tok(jts_pkg::TK_ERROR, '0, '0, jts_pkg::ER_SYNTAX, 1'b0);
        n = n + 2'd1;
        s.prev = jts_pkg::TK_ERROR; s.err = 1'b1; s.mode = jts_pkg::M_IDLE;
      end else begin
        unique case (st.mode)
          jts_pkg::M_LIT: begin
            if (b != jts_pkg::lit_char(sel, p)) s.lmis = 1'b1;
            s.lprog = {1'b0, p} + 4'd1;
            if (s.lprog >= jts_pkg::lit_len(sel)) begin
              s.mode = jts_pkg::M_IDLE;
              if (s.lmis) begin
                r[n] = jts_pkg::mk_tok(jts_pkg::TK_ERROR, '0, '0, jts_pkg::ER_INVALID, 1'b0);
                n = n + 2'd1;
                s.prev = jts_pkg::TK_ERROR; s.err = 1'b1;
              end else begin
                r[n] = jts_pkg::mk_tok(jts_pkg::lit_kind(sel), '0, '0, jts_pkg::ER_NONE, 1'b0);
                n = n + 2'd1;
                s.prev = jts_pkg::lit_kind(sel);
              end
            end
          end
          jts_pkg::M_STR: begin
            if (st.skip) begin
              s.skip = 1'b0;
              taken = (b == "\"") || (b == "\\");
            end
            if (!taken) begin
              if (b == "\"") begin
                hl = ps - ts;
                s.mode = jts_pkg::M_SDONE;
              end else if (b == 8'h00) begin
                r[n] = jts_pkg::mk_tok(jts_pkg::TK_ERROR, '0, '0, jts_pkg::ER_INVALID, 1'b0);
                n = n + 2'd1;
                s.prev = jts_pkg::TK_ERROR; s.err = 1'b1; s.mode = jts_pkg::M_IDLE;
              end else if (b == "\\") begin
                s.esc = 1'b1; s.skip = 1'b1;
              end
            end
          end
          jts_pkg::M_SDONE: begin
            if (space) begin
              s.mode = st.mode;
            end else if (b == ":" || b == "," || b == "]" || b == "}") begin
              r[n] = jts_pkg::mk_tok((b == ":") ? jts_pkg::TK_FIELD : jts_pkg::TK_STR,
                                     16'(ts), 17'(hl), jts_pkg::ER_NONE, s.esc);
              n = n + 2'd1;
              s.mode = jts_pkg::M_IDLE;
              s.prev = (b == ":") ? jts_pkg::TK_FIELD :
                       (b == ",") ? jts_pkg::TK_COMMA : jts_pkg::TK_STR;
              do_idle = (b == "]") || (b == "}");
            end else begin
              r[n] = jts_pkg::mk_tok(jts_pkg::TK_ERROR, '0, '0,
                       (b == 8'h00) ? jts_pkg::ER_INVALID : jts_pkg::ER_SYNTAX, 1'b0);
              n = n + 2'd1;
              s.prev = jts_pkg::TK_ERROR; s.err = 1'b1; s.mode = jts_pkg::M_IDLE;
            end
          end
          jts_pkg::M_NUM: begin
            if (st.sign_only && st.neg_lead && b == "I") begin
              // "-I" turns into the -Infinity literal, first letter matched
              s.mode = jts_pkg::M_LIT; s.lsel = jts_pkg::LIT_LAST;
              s.lprog = 4'd1; s.lmis = 1'b0;
            end else if (digit) begin
              s.sign_only = 1'b0;
            end else if (b == ".") begin
              s.flt = 1'b1; s.sign_only = 1'b0;
            end else if (b == "e" || b == "E" || b == "+" || b == "-" || st.sign_only) begin
              if (!st.flt || !(b == "e" || b == "E" || b == "+" || b == "-")) begin
                r[n] = jts_pkg::mk_tok(jts_pkg::TK_ERROR, '0, '0, jts_pkg::ER_BAD_NUM, 1'b0);
                n = n + 2'd1;
                s.prev = jts_pkg::TK_ERROR; s.err = 1'b1; s.mode = jts_pkg::M_IDLE;
              end
            end else begin
              r[n] = jts_pkg::mk_tok(st.flt ? jts_pkg::TK_FLOAT : jts_pkg::TK_INT,
                                     16'(ts), 17'(ps - ts), jts_pkg::ER_NONE, 1'b0);
              n = n + 2'd1;
              s.prev = st.flt ? jts_pkg::TK_FLOAT : jts_pkg::TK_INT;
              s.mode = jts_pkg::M_IDLE;
              do_idle = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase

        // between tokens; also rescans a byte that closed a number or string
        if (do_idle && !space) begin
          if (b == ",") begin
            if (s.prev == jts_pkg::TK_OBJ_START || s.prev == jts_pkg::TK_ARR_START ||
                s.prev == jts_pkg::TK_FIELD || s.prev == jts_pkg::TK_COMMA) begin
              r[n] = jts_pkg::mk_tok(jts_pkg::TK_ERROR, '0, '0, jts_pkg::ER_COMMA, 1'b0);
              n = n + 2'd1;
              s.prev = jts_pkg::TK_ERROR; s.err = 1'b1; s.mode = jts_pkg::M_IDLE;
            end else begin
              s.prev = jts_pkg::TK_COMMA;
            end
          end else if (b == "{" || b == "[") begin
            s.prev = (b == "{") ? jts_pkg::TK_OBJ_START : jts_pkg::TK_ARR_START;
            r[n] = jts_pkg::mk_tok(s.prev, '0, '0, jts_pkg::ER_NONE, 1'b0);
            n = n + 2'd1;
          end else if (b == "}" || b == "]") begin
            if (s.prev == jts_pkg::TK_COMMA) begin
              r[n] = jts_pkg::mk_tok(jts_pkg::TK_ERROR, '0, '0, jts_pkg::ER_TRAILING, 1'b0);
              n = n + 2'd1;
              s.prev = jts_pkg::TK_ERROR; s.err = 1'b1; s.mode = jts_pkg::M_IDLE;
            end else begin
              s.prev = (b == "}") ? jts_pkg::TK_OBJ_END : jts_pkg::TK_ARR_END;
              r[n] = jts_pkg::mk_tok(s.prev, '0, '0, jts_pkg::ER_NONE, 1'b0);
              n = n + 2'd1;
            end
          end else if (b == "n" || b == "t" || b == "f" || b == "u" || b == "N" ||
                       b == "I") begin
            s.mode  = jts_pkg::M_LIT;
            s.lsel  = (b == "n") ? 3'd0 : (b == "t") ? 3'd1 : (b == "f") ? 3'd2 :
                      (b == "u") ? 3'd3 : (b == "N") ? 3'd4 : 3'd5;
            s.lprog = 4'd0;
            s.lmis  = 1'b0;
          end else if (b == "\"") begin
            s.mode = jts_pkg::M_STR;
            ts     = ps + PW'(1);
            s.esc  = 1'b0;
            s.skip = 1'b0;
          end else if (b == "+" || b == "-" || digit) begin
            s.mode      = jts_pkg::M_NUM;
            ts          = ps;
            s.flt       = 1'b0;
            s.sign_only = (b == "+") || (b == "-");
            s.neg_lead  = (b == "-");
          end else begin
            r[n] = jts_pkg::mk_tok(jts_pkg::TK_ERROR, '0, '0, jts_pkg::ER_INVALID, 1'b0);
            n = n + 2'd1;
            s.prev = jts_pkg::TK_ERROR; s.err = 1'b1; s.mode = jts_pkg::M_IDLE;
          end
        end
        ps = ps + PW'(1);
      end
    end

    if (item.row_end) begin
      if (!s.err) begin
        unique case (s.mode)
          jts_pkg::M_NUM: begin
            if (s.sign_only) begin
              r[n] = jts_pkg::mk_tok(jts_pkg::TK_ERROR, '0, '0, jts_pkg::ER_BAD_NUM, 1'b0);
            end else begin
              r[n] = jts_pkg::mk_tok(s.flt ? jts_pkg::TK_FLOAT : jts_pkg::TK_INT,
                                     16'(ts), 17'(ps - ts), jts_pkg::ER_NONE, 1'b0);
            end
            n = n + 2'd1;
          end
          jts_pkg::M_STR: begin
            r[n] = jts_pkg::mk_tok(jts_pkg::TK_ERROR, '0, '0, jts_pkg::ER_UNTERM, 1'b0);
            n = n + 2'd1;
          end
          jts_pkg::M_SDONE: begin
            r[n] = jts_pkg::mk_tok(jts_pkg::TK_STR, 16'(ts), 17'(hl), jts_pkg::ER_NONE, s.esc);
            n = n + 2'd1;
          end
          jts_pkg::M_LIT: begin
            r[n] = jts_pkg::mk_tok(jts_pkg::TK_ERROR, '0, '0, jts_pkg::ER_PREMATURE, 1'b0);
            n = n + 2'd1;
          end
          default: n = n;
        endcase
      end
      r[n] = jts_pkg::mk_tok(jts_pkg::TK_END, '0, '0, jts_pkg::ER_NONE, 1'b0);
      n = n + 2'd1;
      s  = jts_pkg::SCAN_RESET;
      ps = '0;
      ts = '0;
      hl = '0;
    end

    if (n != 2'd0) r[n - 2'd1].run_last = 1'b1;

    st_next     = s;
    pos_next    = ps;
    tstart_next = ts;
    held_next   = hl;
    res_cnt     = n;
    for (int i = 0; i < 3; i++) begin
      res[i] = r[i];
    end
  end

endmodule

// ===== design/jts_queue.sv =====
module jts_queue (
  input  logic               clk,
  input  logic               rst,
  input  jts_pkg::tok_beat_t push_data [3],
  input  logic [1:0]         push_cnt,
  output logic               room,
  output logic               tok_valid,
  input  logic               tok_ready,
  output jts_pkg::tok_beat_t tok
);

  localparam int DEPTH = 8;
  localparam int AW    = $clog2(DEPTH);

  jts_pkg::tok_beat_t mem [DEPTH];
  logic [AW-1:0]      wr_ptr, rd_ptr;
  logic [AW:0]        count, count_next;
  logic               pop;

  assign pop        = tok_valid && tok_ready;
  assign tok_valid  = (count != '0);
  assign tok        = mem[rd_ptr];
  // space for the largest burst one item can cause
  assign room       = (count <= (AW + 1)'(DEPTH - 3));
  assign count_next = count + (AW + 1)'(push_cnt) - (AW + 1)'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_cnt) mem[wr_ptr + AW'(i)] <= push_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_cnt);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count_next;
    end
  end

endmodule

// ===== design/json_token_scanner.sv =====
// json_token_scanner: byte-serial JSON row tokenizer.
//
// Input channel (item_valid/item_ready/item): one beat carries one row byte,
// a byte_present flag and a row_end flag. An item with byte_present low and
// row_end high just closes the row; one with both low is a no-op.
// Output channel (tok_valid/tok_ready/tok): one beat per token. Each input
// item produces zero to three beats; run_last marks the final one of a burst.
// The tokens of an item are registered into the queue when the item is
// taken. Throughput: one item per cycle while tokens are drained. Results
// sit in an 8-entry queue; item_ready drops when fewer than 3 free slots
// remain, so a stalled receiver backs up into the input, nothing lost.
// Reset (rst, synchronous): row state goes to idle between tokens, the
// queue empties, tok_valid is low the cycle after. End of row does the same
// row-state reset internally after emitting the End token.
module json_token_scanner #(
  parameter int MAX_ROW_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  jts_pkg::item_t     item,
  output logic               tok_valid,
  input  logic               tok_ready,
  output jts_pkg::tok_beat_t tok
);

  localparam int PW = $clog2(MAX_ROW_BYTES + 1);

  // row state registers
  jts_pkg::scan_st_t  st, st_next;
  logic [PW-1:0]      pos, pos_next;
  logic [PW-1:0]      tstart, tstart_next;
  logic [PW-1:0]      held, held_next;

  jts_pkg::tok_beat_t res [3];
  logic [1:0]         res_cnt;
  logic               room, take;

  assign item_ready = room;
  assign take       = item_valid && item_ready;

  jts_step #(.MAX_ROW_BYTES(MAX_ROW_BYTES), .PW(PW)) u_step (
    .st          (st),
    .pos         (pos),
    .tstart      (tstart),
    .held        (held),
    .item        (item),
    .st_next     (st_next),
    .pos_next    (pos_next),
    .tstart_next (tstart_next),
    .held_next   (held_next),
    .res         (res),
    .res_cnt     (res_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= jts_pkg::SCAN_RESET;
      pos    <= '0;
      tstart <= '0;
      held   <= '0;
    end else if (take) begin
      st     <= st_next;
      pos    <= pos_next;
      tstart <= tstart_next;
      held   <= held_next;
    end
  end

  // tokens land in the queue only for an accepted beat
  jts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_data (res),
    .push_cnt  (take ? res_cnt : 2'd0),
    .room      (room),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

endmodule

// ===== design/jts_checker.sv =====
module jts_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input jts_pkg::item_t     item,
  input logic               tok_valid,
  input logic               tok_ready,
  input jts_pkg::tok_beat_t tok
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !tok_valid)
    else $error("token valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(tok))
    else $error("stalled token changed");

  a_end_gives_tok: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.row_end |=> tok_valid)
    else $error("row end produced no token");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok.token_kind == 4'(jts_pkg::TK_END) |-> tok.run_last)
    else $error("End token not last of burst");

  a_error_coded: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok.token_kind == 4'(jts_pkg::TK_ERROR) |->
    tok.error_kind != jts_pkg::ER_NONE)
    else $error("Error token without error kind");

endmodule

bind json_token_scanner jts_checker u_jts_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_ready (item_ready),
  .item       (item),
  .tok_valid  (tok_valid),
  .tok_ready  (tok_ready),
  .tok        (tok)
);
